[hdl/fdhm_pkg.sv]
// ----------------------------------------------------------------------------
// fdhm_pkg
// Shared types and constants of the floppy drive head and motor control.
// ----------------------------------------------------------------------------
package fdhm_pkg;

   // item kinds on the request channel
   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_STEP     = 2'd1,
      REQ_TRANSFER = 2'd2,
      REQ_REINIT   = 2'd3
   } req_kind_type;

   // activity light codes
   localparam logic [1:0] LED_OFF     = 2'd0;
   localparam logic [1:0] LED_PENDING = 2'h1;
   localparam logic [1:0] LED_RUNNING = 2'h3;

   // head travel limits
   localparam logic [7:0] LOW_TRACK_LIMIT = 8'd80;
   localparam logic [7:0] DEFAULT_TOP     = 8'd81;
   localparam logic [7:0] CAP_TOP         = 8'd254;

   // register file: index of each register, byte address is 4 * index
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_COUNT       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_COUNT        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTORS_PER_TRACK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISK_PRESENT      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPIN_TIME         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLUSH_DELAY_LIMIT = 3'd5;

   // register reset values
   localparam logic [14:0] SPIN_TIME_RESET   = 15'd1000;
   localparam logic [15:0] FLUSH_DELAY_RESET = 16'd2000;

endpackage

[hdl/fdhm_req_if.sv]
// ----------------------------------------------------------------------------
// fdhm_req_if
// Request channel: one drive event per item.
// ----------------------------------------------------------------------------
interface fdhm_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic signed [7:0] step_amount;
   logic [7:0]        track_num;
   logic [7:0]        sector_num;
   logic              head_side;
   logic              motor_request;
   logic              track_dirty;

   modport source (
      output valid, req_type, step_amount, track_num, sector_num, head_side,
             motor_request, track_dirty,
      input  ready
   );
   modport sink (
      input  valid, req_type, step_amount, track_num, sector_num, head_side,
             motor_request, track_dirty,
      output ready
   );
endinterface

[hdl/fdhm_rsp_if.sv]
// ----------------------------------------------------------------------------
// fdhm_rsp_if
// Result channel: one result item for every request item.
// ----------------------------------------------------------------------------
interface fdhm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] led_code;
   logic       flush_request;
   logic       transfer_ok;
   logic [7:0] sector_index;
   logic [7:0] head_track;
   logic       motor_running;

   modport source (
      output valid, led_code, flush_request, transfer_ok, sector_index,
             head_track, motor_running,
      input  ready
   );
   modport sink (
      input  valid, led_code, flush_request, transfer_ok, sector_index,
             head_track, motor_running,
      output ready
   );
endinterface

[hdl/floppy_drive_head_motor_control.sv]
// ----------------------------------------------------------------------------
// floppy_drive_head_motor_control
// Head position, motor spin counter and transfer check of one floppy drive.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries drive events (tick, head step, start transfer,
//   re-initialise). Every request item gives exactly one item on rsp_ch with
//   the light code, flush request, transfer verdict and the head and motor
//   state after the event.
//   The item is latched into an input register, then evaluated against the
//   drive state and written to the result register, from which it is
//   offered on rsp_ch. One item per cycle is taken sustained while rsp_ch
//   is ready; the limit is the state update (head, counter, motor) between
//   the two registers.
//   When rsp_ch stalls, the result register holds its item and the input
//   register holds one more; req_ch.ready drops only when both are full.
//   The APB port (psel/penable/pwrite/paddr/pwdata) sets the disk geometry
//   and timing; registers lie at byte address 4 * index, pready is always
//   high and writes belong in idle periods.
//   Reset (synchronous, active high) clears head, counter and motor, empties
//   both registers and loads the register reset values.
// ----------------------------------------------------------------------------
module floppy_drive_head_motor_control (
   input  logic                            clock,
   input  logic                            reset,
   fdhm_req_if.sink                        req_ch,
   fdhm_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fdhm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import fdhm_pkg::*;

   // configuration registers
   logic [7:0]  track_count_ff;
   logic [1:0]  side_count_ff;
   logic [7:0]  sectors_per_track_ff;
   logic        disk_present_ff;
   logic [14:0] spin_time_ff;
   logic [15:0] flush_delay_limit_ff;

   // drive state
   logic [7:0]  head_ff, head_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        motor_ff, motor_in;

   // input register
   logic              in_valid_ff;
   logic [1:0]        type_ff;
   logic signed [7:0] amount_ff;
   logic [7:0]        track_ff;
   logic [7:0]        sector_ff;
   logic              side_ff;
   logic              mreq_ff;
   logic              dirty_ff;

   // result register
   logic        out_valid_ff;
   logic [1:0]  led_ff, led_in;
   logic        flush_ff, flush_in;
   logic        ok_ff, ok_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  htrack_ff;
   logic        mrun_ff;

   logic [CSR_INDEX_W-1:0] csr_index;
   logic        csr_write;
   logic        advance;
   logic [15:0] spin_ext;
   logic [15:0] cnt_dec;
   logic [7:0]  top_limit;
   logic signed [9:0] step_sum;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         track_count_ff       <= '0;
         side_count_ff        <= '0;
         sectors_per_track_ff <= '0;
         disk_present_ff      <= 1'b0;
         spin_time_ff         <= SPIN_TIME_RESET;
         flush_delay_limit_ff <= FLUSH_DELAY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TRACK_COUNT:       track_count_ff       <= pwdata[7:0];
            CSR_SIDE_COUNT:        side_count_ff        <= pwdata[1:0];
            CSR_SECTORS_PER_TRACK: sectors_per_track_ff <= pwdata[7:0];
            CSR_DISK_PRESENT:      disk_present_ff      <= pwdata[0];
            CSR_SPIN_TIME:         spin_time_ff         <= pwdata[14:0];
            CSR_FLUSH_DELAY_LIMIT: flush_delay_limit_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         CSR_TRACK_COUNT:       prdata = {24'd0, track_count_ff};
         CSR_SIDE_COUNT:        prdata = {30'd0, side_count_ff};
         CSR_SECTORS_PER_TRACK: prdata = {24'd0, sectors_per_track_ff};
         CSR_DISK_PRESENT:      prdata = {31'd0, disk_present_ff};
         CSR_SPIN_TIME:         prdata = {17'd0, spin_time_ff};
         CSR_FLUSH_DELAY_LIMIT: prdata = {16'd0, flush_delay_limit_ff};
         default:               prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   // the held item moves on when the result register is free or draining
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         type_ff   <= req_ch.req_type;
         amount_ff <= req_ch.step_amount;
         track_ff  <= req_ch.track_num;
         sector_ff <= req_ch.sector_num;
         side_ff   <= req_ch.head_side;
         mreq_ff   <= req_ch.motor_request;
         dirty_ff  <= req_ch.track_dirty;
      end
   end

   // ---------------- event evaluation ----------------
   assign spin_ext = {1'b0, spin_time_ff};
   assign cnt_dec  = cnt_ff - 16'd1;
   assign step_sum = $signed({2'b00, head_ff}) + 10'(amount_ff);

   // upper head limit from the track count
   always_comb begin
      if (track_count_ff > LOW_TRACK_LIMIT) begin
         top_limit = (track_count_ff < CAP_TOP) ? track_count_ff + 8'd1 : CAP_TOP;
      end else begin
         top_limit = DEFAULT_TOP;
      end
   end

   always_comb begin
      head_in  = head_ff;
      cnt_in   = cnt_ff;
      motor_in = motor_ff;
      led_in   = LED_OFF;
      flush_in = 1'b0;
      ok_in    = 1'b0;
      index_in = '0;
      case (req_kind_type'(type_ff))
         REQ_TICK: begin
            if (cnt_ff == '0) begin
               led_in = LED_OFF;
            end else if (cnt_ff > spin_ext) begin
               // delayed flush pending
               if (!dirty_ff) begin
                  cnt_in = '0;
               end else if (cnt_dec == spin_ext) begin
                  flush_in = 1'b1;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_dec;
                  led_in = LED_PENDING;
               end
            end else if (mreq_ff) begin
               // spin up toward spin_time
               if (cnt_ff < spin_ext) begin
                  cnt_in = cnt_ff + 16'd1;
               end
               led_in = LED_RUNNING;
            end else if (cnt_dec == '0) begin
               // spin-down finished
               motor_in = 1'b0;
               if (dirty_ff) begin
                  cnt_in = flush_delay_limit_ff;
                  led_in = LED_PENDING;
               end else begin
                  cnt_in = '0;
               end
            end else begin
               cnt_in = cnt_dec;
               led_in = LED_RUNNING;
            end
         end
         REQ_STEP: begin
            if (step_sum < 10'sd0) begin
               head_in = '0;
            end else if (step_sum > $signed({2'b00, top_limit})) begin
               head_in = top_limit;
            end else begin
               head_in = step_sum[7:0];
            end
         end
         REQ_TRANSFER: begin
            if (motor_ff && (head_ff < track_count_ff) &&
                ({1'b0, side_ff} < side_count_ff) && (head_ff == track_ff) &&
                (sector_ff != '0) && (sector_ff <= sectors_per_track_ff)) begin
               ok_in    = 1'b1;
               index_in = sector_ff - 8'd1;
            end
         end
         REQ_REINIT: begin
            flush_in = dirty_ff;
            head_in  = '0;
            motor_in = disk_present_ff;
            cnt_in   = disk_present_ff ? spin_ext : '0;
         end
         default: ;
      endcase
   end

   // drive state update as the item completes
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         cnt_ff   <= '0;
         motor_ff <= 1'b0;
      end else if (advance) begin
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
         motor_ff <= motor_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         led_ff    <= led_in;
         flush_ff  <= flush_in;
         ok_ff     <= ok_in;
         index_ff  <= index_in;
         htrack_ff <= head_in;
         mrun_ff   <= motor_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.led_code      = led_ff;
   assign rsp_ch.flush_request = flush_ff;
   assign rsp_ch.transfer_ok   = ok_ff;
   assign rsp_ch.sector_index  = index_ff;
   assign rsp_ch.head_track    = htrack_ff;
   assign rsp_ch.motor_running = mrun_ff;

   // ---------------- assertions ----------------
   // head never leaves the travel range
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= CAP_TOP)
      else $error("head position beyond top limit");

   // a re-initialise item brings the head home
   a_reinit_home: assert property (@(posedge clock) disable iff (reset)
      advance && (type_ff == REQ_REINIT) |=> head_ff == '0)
      else $error("head not home after re-initialise");

   // an accepted transfer needs a running motor
   a_ok_motor: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && ok_ff |-> mrun_ff)
      else $error("transfer accepted with motor stopped");

   // a stalled result is not overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> out_valid_ff && $stable(htrack_ff)
         && $stable(led_ff) && $stable(index_ff))
      else $error("stalled result changed");

   // a counter at rest gives a dark light
   a_light_idle: assert property (@(posedge clock) disable iff (reset)
      advance && (type_ff == REQ_TICK) && (cnt_ff == '0) |=> led_ff == LED_OFF)
      else $error("light on with idle counter");

endmodule
